// File: rtl/core/pdli_pkg.sv
// ----------------------------------------------------------------------------
// pdli_pkg
// Types and constants shared by the plane distance / line intersect pipeline.
// ----------------------------------------------------------------------------
package pdli_pkg;

  localparam int NUM_W      = 50;   // signed n.p + d and n.v in Q.30
  localparam int MAG_W      = 49;   // magnitude of those
  localparam int PROD_W     = 80;   // |v| * |num|
  localparam int SPLIT      = 25;   // low slice of |num| for the split multiply
  localparam int DIV_STEPS  = 40;   // quotient bits below the cap
  localparam int QUO_W      = DIV_STEPS + 1;
  localparam int DIV_BITS   = 2;    // quotient bits per divider stage
  localparam int DIV_STAGES = DIV_STEPS / DIV_BITS;
  localparam int DIV_LAT    = DIV_STAGES + 2;
  localparam int QSHIFT     = 14;

  typedef enum logic [1:0] {
    REG_NORMAL_X     = 2'd0,
    REG_NORMAL_Y     = 2'd1,
    REG_NORMAL_Z     = 2'd2,
    REG_PLANE_OFFSET = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } cmd_t;

  typedef struct packed {
    logic        [30:0] distance;
    logic               hit;
    logic signed [31:0] isect_x;
    logic signed [31:0] isect_y;
    logic signed [31:0] isect_z;
    logic               overflow;
  } res_t;

  // per-item data that rides alongside the dividers
  typedef struct packed {
    logic                   mode;
    logic signed [2:0][31:0] pos;
    logic        [2:0]      neg;
    logic                   den_zero;
    logic        [30:0]     distance;
    logic                   dist_ovf;
  } side_t;

endpackage

// File: rtl/core/pdli_div.sv
// ----------------------------------------------------------------------------
// pdli_div
// Pipelined restoring divider, DIV_BITS quotient bits per stage. Gives
// round-half-up(prod / den), capped at 2^40.
// ----------------------------------------------------------------------------
module pdli_div import pdli_pkg::*; (
  input  logic              clk,
  input  logic [PROD_W-1:0] prod,
  input  logic [MAG_W-1:0]  den,
  output logic [QUO_W-1:0]  quo
);

  logic [MAG_W:0]     rem_s [0:DIV_STAGES];
  logic [DIV_STEPS-1:0] low_s [0:DIV_STAGES];
  logic [DIV_STEPS-1:0] q_s   [0:DIV_STAGES];
  logic [MAG_W-1:0]   den_s [0:DIV_STAGES];
  logic               big_s [0:DIV_STAGES];

  // upper part already >= den means the quotient reaches the cap
  always_ff @(posedge clk) begin
    rem_s[0] <= (MAG_W+1)'(prod[PROD_W-1:DIV_STEPS]);
    low_s[0] <= prod[DIV_STEPS-1:0];
    q_s[0]   <= '0;
    den_s[0] <= den;
    big_s[0] <= MAG_W'(prod[PROD_W-1:DIV_STEPS]) >= den;
  end

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic [MAG_W:0]       r;
    logic [DIV_STEPS-1:0] l;
    logic [DIV_STEPS-1:0] q;

    always_comb begin
      r = rem_s[g];
      l = low_s[g];
      q = q_s[g];
      for (int j = 0; j < DIV_BITS; j++) begin
        r = {r[MAG_W-1:0], l[DIV_STEPS-1]};
        l = {l[DIV_STEPS-2:0], 1'b0};
        q = {q[DIV_STEPS-2:0], 1'b0};
        if (r >= {1'b0, den_s[g]}) begin
          r    = r - {1'b0, den_s[g]};
          q[0] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      rem_s[g+1] <= r;
      low_s[g+1] <= l;
      q_s[g+1]   <= q;
      den_s[g+1] <= den_s[g];
      big_s[g+1] <= big_s[g];
    end
  end

  logic rnd;
  assign rnd = rem_s[DIV_STAGES] >= ({1'b0, den_s[DIV_STAGES]} - rem_s[DIV_STAGES]);

  always_ff @(posedge clk) begin
    if (big_s[DIV_STAGES]) begin
      quo <= QUO_W'(1) << DIV_STEPS;
    end else begin
      quo <= QUO_W'(q_s[DIV_STAGES]) + QUO_W'(rnd);
    end
  end

endmodule

// File: rtl/core/plane_distance_line_intersect.sv
// ----------------------------------------------------------------------------
// plane_distance_line_intersect
// Point-to-plane distance and line/plane intersection against a configured
// plane n.x + d = 0.
// ----------------------------------------------------------------------------
// Fully pipelined: busy never rises, one item may start every cycle, and each
// item gives its result on done, in the order of acceptance. Each item passes
// the capture register, four front stages for the dot products and the split
// multiply, the three-lane divider (two quotient bits per stage over 40
// quotient bits, plus input and rounding registers) and the output register.
// The receiver cannot stall; results must be taken on done. Plane registers
// may be written only while no item is in flight.
module plane_distance_line_intersect import pdli_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  cmd_t        cmd,
  output logic        done,
  output res_t        result,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [31:0] cfg_wdata
);

  logic signed [15:0] nrm [3];
  logic signed [31:0] plane_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      nrm[0]       <= 16'sd0;
      nrm[1]       <= 16'sd0;
      nrm[2]       <= 16'sd16384;
      plane_offset <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_idx))
        REG_NORMAL_X:     nrm[0]       <= cfg_wdata[15:0];
        REG_NORMAL_Y:     nrm[1]       <= cfg_wdata[15:0];
        REG_NORMAL_Z:     nrm[2]       <= cfg_wdata[15:0];
        REG_PLANE_OFFSET: plane_offset <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // valid bits per stage: S1..S5, divider delay, output
  logic [4:0]         vld;
  logic [DIV_LAT-1:0] vld_div;

  // S1: capture item
  cmd_t               it1;
  logic signed [31:0] pos1 [3];
  logic signed [31:0] dir1 [3];
  always_ff @(posedge clk) it1 <= cmd;
  assign pos1[0] = it1.pos_x;
  assign pos1[1] = it1.pos_y;
  assign pos1[2] = it1.pos_z;
  assign dir1[0] = it1.dir_x;
  assign dir1[1] = it1.dir_y;
  assign dir1[2] = it1.dir_z;

  // S2: normal products
  logic signed [47:0] pn2 [3];
  logic signed [47:0] dn2 [3];
  logic signed [31:0] pos2 [3];
  logic signed [31:0] dir2 [3];
  logic               mode2;
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      pn2[k]  <= 48'(nrm[k]) * 48'(pos1[k]);
      dn2[k]  <= 48'(nrm[k]) * 48'(dir1[k]);
      pos2[k] <= pos1[k];
      dir2[k] <= dir1[k];
    end
    mode2 <= it1.mode;
  end

  // S3: dot sums
  logic signed [NUM_W-1:0] num3, den3;
  logic signed [31:0]      pos3 [3];
  logic signed [31:0]      dir3 [3];
  logic                    mode3;
  always_ff @(posedge clk) begin
    num3 <= NUM_W'(pn2[0]) + NUM_W'(pn2[1]) + NUM_W'(pn2[2])
          + (NUM_W'(plane_offset) <<< QSHIFT);
    den3 <= NUM_W'(dn2[0]) + NUM_W'(dn2[1]) + NUM_W'(dn2[2]);
    for (int k = 0; k < 3; k++) begin
      pos3[k] <= pos2[k];
      dir3[k] <= dir2[k];
    end
    mode3 <= mode2;
  end

  // S4: split multiply |v| * |num|, distance
  logic [MAG_W-1:0]  numm3, denm3;
  logic [31:0]       vm3 [3];
  logic [MAG_W:0]    dsum3;
  logic [35:0]       dist3;
  assign numm3 = MAG_W'(num3[NUM_W-1] ? -num3 : num3);
  assign denm3 = MAG_W'(den3[NUM_W-1] ? -den3 : den3);
  assign dsum3 = (MAG_W+1)'(numm3) + (MAG_W+1)'(1 << (QSHIFT - 1));
  assign dist3 = 36'(dsum3 >> QSHIFT);
  for (genvar k = 0; k < 3; k++) begin : g_vm
    assign vm3[k] = dir3[k][31] ? 32'(-dir3[k]) : 32'(dir3[k]);
  end

  logic [SPLIT+31:0]         pp_lo4 [3];
  logic [MAG_W-SPLIT+31:0]   pp_hi4 [3];
  logic [MAG_W-1:0]          denm4;
  side_t                     sb4;
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      pp_lo4[k] <= (SPLIT+32)'(vm3[k]) * (SPLIT+32)'(numm3[SPLIT-1:0]);
      pp_hi4[k] <= (MAG_W-SPLIT+32)'(vm3[k])
                 * (MAG_W-SPLIT+32)'(numm3[MAG_W-1:SPLIT]);
      sb4.pos[k] <= pos3[k];
      sb4.neg[k] <= dir3[k][31] ^ num3[NUM_W-1] ^ den3[NUM_W-1];
    end
    denm4        <= denm3;
    sb4.mode     <= mode3;
    sb4.den_zero <= den3 == '0;
    sb4.dist_ovf <= dist3 > 36'h07FFF_FFFF;
    sb4.distance <= (dist3 > 36'h07FFF_FFFF) ? '1 : dist3[30:0];
  end

  // S5: full product
  logic [PROD_W-1:0] prod5 [3];
  logic [MAG_W-1:0]  denm5;
  side_t             sb_pipe [0:DIV_LAT];
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      prod5[k] <= PROD_W'(pp_lo4[k]) + (PROD_W'(pp_hi4[k]) << SPLIT);
    end
    denm5      <= denm4;
    sb_pipe[0] <= sb4;
    for (int i = 1; i <= DIV_LAT; i++) begin
      sb_pipe[i] <= sb_pipe[i-1];
    end
  end

  logic [QUO_W-1:0] quo [3];
  for (genvar k = 0; k < 3; k++) begin : g_div
    pdli_div u_div (
      .clk  (clk),
      .prod (prod5[k]),
      .den  (denm5),
      .quo  (quo[k])
    );
  end

  // output: p - term, saturate
  side_t              sbo;
  logic signed [42:0] diff [3];
  logic signed [31:0] isect [3];
  logic [2:0]         sat;
  assign sbo = sb_pipe[DIV_LAT];
  for (genvar k = 0; k < 3; k++) begin : g_out
    logic signed [42:0] qs;
    assign qs      = signed'(43'(quo[k]));
    assign diff[k] = 43'($signed(sbo.pos[k])) - (sbo.neg[k] ? -qs : qs);
    always_comb begin
      sat[k]   = 1'b1;
      isect[k] = diff[k][31:0];
      if (diff[k] > 43'sh0_7FFF_FFFF) begin
        isect[k] = 32'sh7FFF_FFFF;
      end else if (diff[k] < -43'sh0_8000_0000) begin
        isect[k] = -32'sh8000_0000;
      end else begin
        sat[k] = 1'b0;
      end
    end
  end

  res_t result_next;
  always_comb begin
    result_next = '0;
    if (!sbo.mode) begin
      result_next.distance = sbo.distance;
      result_next.overflow = sbo.dist_ovf;
    end else if (!sbo.den_zero) begin
      result_next.hit      = 1'b1;
      result_next.isect_x  = isect[0];
      result_next.isect_y  = isect[1];
      result_next.isect_z  = isect[2];
      result_next.overflow = |sat;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      vld_div <= '0;
      done    <= 1'b0;
    end else begin
      vld     <= {vld[3:0], start & ~busy};
      vld_div <= {vld_div[DIV_LAT-2:0], vld[4]};
      done    <= vld_div[DIV_LAT-1];
    end
  end

  a_start_tracked: assert property (@(posedge clk) disable iff (rst)
    start |=> vld[0]) else $error("accepted item lost at entry");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.hit |-> result.isect_x == 0 && result.isect_y == 0
                            && result.isect_z == 0)
    else $error("intersection point without hit");

  a_hit_no_dist: assert property (@(posedge clk) disable iff (rst)
    done && result.hit |-> result.distance == 0)
    else $error("distance set on a line item");

  a_dist_sat: assert property (@(posedge clk) disable iff (rst)
    done && !result.hit && result.overflow |-> &result.distance)
    else $error("distance overflow without saturation");

  a_done_from_pipe: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(vld_div[DIV_LAT-1]))
    else $error("result strobe without item");

endmodule

// File: tb/plane_distance_line_intersect_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plane_distance_line_intersect_test
// Self-checking bench for the plane query pipeline. Commands are driven with
// random gaps under several plane settings; every done is compared with a
// model of distance and line intersection or a fixed expected result.
// ----------------------------------------------------------------------------
module plane_distance_line_intersect_test;
  import pdli_pkg::*;

  localparam int HALF      = 10;
  localparam int LATENCY   = 27;
  localparam int WDOG_MAX  = 2000;
  localparam int N_RANDOM  = 1700;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  cmd_t        cmd = '0;
  logic        done;
  res_t        result;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = '0;
  logic [31:0] cfg_wdata = '0;

  plane_distance_line_intersect dut (.*);

  always #HALF clk = ~clk;

  // plane copy used by the predictor
  logic signed [15:0] pl_nx, pl_ny, pl_nz;
  logic signed [31:0] pl_d;

  res_t pending_q[$];
  int   errors = 0;
  int   idle_pct = 0;
  int   quiet = 0;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // |v| * |num| / |den| rounded half away, capped at 2^40
  function automatic logic [63:0] ratio_term(input logic [63:0] a, b, den);
    logic [127:0] prod;
    logic [127:0] q, r;
    prod = 128'(a) * 128'(b);
    q = prod / 128'(den);
    r = prod % 128'(den);
    if (q >= (128'd1 << 40)) return 64'd1 << 40;
    if (r >= 128'(den) - r) q = q + 1;
    return q[63:0];
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v,
                                                 inout logic ovf);
    if (v > 64'sd2147483647) begin
      ovf = 1'b1;
      return 32'h7fffffff;
    end
    if (v < -64'sd2147483648) begin
      ovf = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  function automatic res_t plane_query(input cmd_t c);
    res_t r;
    logic signed [63:0] num, den, term;
    logic signed [63:0] p[3], v[3];
    logic [63:0] dist_mag, q;
    logic neg, ovf;
    r = '0;
    ovf = 1'b0;
    p[0] = c.pos_x; p[1] = c.pos_y; p[2] = c.pos_z;
    v[0] = c.dir_x; v[1] = c.dir_y; v[2] = c.dir_z;
    num = 64'(pl_nx) * p[0] + 64'(pl_ny) * p[1] + 64'(pl_nz) * p[2]
        + (64'(pl_d) <<< QSHIFT);
    if (!c.mode) begin
      dist_mag = (mag64(num) + (64'd1 << (QSHIFT - 1))) >> QSHIFT;
      if (dist_mag > 64'd2147483647) begin
        dist_mag = 64'd2147483647;
        ovf = 1'b1;
      end
      r.distance = dist_mag[30:0];
      r.overflow = ovf;
      return r;
    end
    den = 64'(pl_nx) * v[0] + 64'(pl_ny) * v[1] + 64'(pl_nz) * v[2];
    if (den == 0) return r;
    r.hit = 1'b1;
    for (int k = 0; k < 3; k++) begin
      q = ratio_term(mag64(v[k]), mag64(num), mag64(den));
      neg = ((v[k] < 0) != (num < 0)) != (den < 0);
      term = neg ? -$signed(q) : $signed(q);
      case (k)
        0: r.isect_x = clamp32(p[k] - term, ovf);
        1: r.isect_y = clamp32(p[k] - term, ovf);
        default: r.isect_z = clamp32(p[k] - term, ovf);
      endcase
    end
    r.overflow = ovf;
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    res_t want;
    if (!rst && done) begin
      if (pending_q.size() == 0) begin
        $error("result with no item outstanding");
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (result.distance !== want.distance) begin
          $error("distance exp %h got %h", want.distance, result.distance); errors++;
        end
        if (result.hit !== want.hit) begin
          $error("hit exp %b got %b", want.hit, result.hit); errors++;
        end
        if (result.isect_x !== want.isect_x) begin
          $error("isect_x exp %h got %h", want.isect_x, result.isect_x); errors++;
        end
        if (result.isect_y !== want.isect_y) begin
          $error("isect_y exp %h got %h", want.isect_y, result.isect_y); errors++;
        end
        if (result.isect_z !== want.isect_z) begin
          $error("isect_z exp %h got %h", want.isect_z, result.isect_z); errors++;
        end
        if (result.overflow !== want.overflow) begin
          $error("overflow exp %b got %b", want.overflow, result.overflow); errors++;
        end
      end
    end
  end

  // watchdog: cycles with nothing accepted and no result
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WDOG_MAX) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_plane(input reg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_NORMAL_X: pl_nx = val[15:0];
      REG_NORMAL_Y: pl_ny = val[15:0];
      REG_NORMAL_Z: pl_nz = val[15:0];
      default:      pl_d = val;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_plane(input logic [15:0] nx, ny, nz, input logic [31:0] d);
    write_plane(REG_NORMAL_X, 32'(nx));
    write_plane(REG_NORMAL_Y, 32'(ny));
    write_plane(REG_NORMAL_Z, 32'(nz));
    write_plane(REG_PLANE_OFFSET, d);
  endtask

  // called at a falling edge; returns at a falling edge after acceptance
  task automatic issue(input cmd_t c, input logic chk, input res_t fixed);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_q.push_back(chk ? fixed : plane_query(c));
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (pending_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 3) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(2000000)) - 1000000);
      2: return {{12{1'($urandom_range(1))}}, 20'($urandom())};
      default: return 32'($signed($urandom_range(20)) - 10) <<< 16;
    endcase
  endfunction

  function automatic logic [15:0] rand_normal();
    case ($urandom_range(3))
      0: return 16'($signed($urandom_range(32768)) - 16384);
      1: return 16'd16384;
      2: return 16'hc000;
      default: return 16'($urandom());
    endcase
  endfunction

  typedef struct {
    cmd_t c;
    logic chk;
    res_t r;
  } row_t;

  initial begin
    row_t dirs[$];
    row_t row;
    cmd_t c;
    int   ph;
    pl_nx = 0; pl_ny = 0; pl_nz = 16'sd16384; pl_d = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, reset plane z = 0
    row = '{c: '0, chk: 1'b1, r: '0}; dirs.push_back(row);
    row.c = '0; row.c.pos_z = 32'sh7fffffff; row.r = '0;
    row.r.distance = 31'h7fffffff; dirs.push_back(row);
    row.c = '0; row.c.pos_z = 32'sh80000000; row.r = '0;
    row.r.distance = 31'h7fffffff; row.r.overflow = 1'b1; dirs.push_back(row);
    row.c = '0; row.c.mode = 1'b1; row.c.dir_x = 32'h10000; row.r = '0;
    dirs.push_back(row);   // parallel line
    row.chk = 1'b0;
    row.c = '0; row.c.mode = 1'b1; row.c.pos_z = 32'h50000; row.c.dir_z = 32'hffff0000;
    dirs.push_back(row);
    row.c = '0; row.c.mode = 1'b1; row.c.pos_x = 32'sh7fffffff; row.c.pos_z = 32'h10000;
    row.c.dir_x = 32'h80000000; row.c.dir_z = 32'h1; dirs.push_back(row);
    row.c = '1; dirs.push_back(row);
    row.c = '0; row.c.mode = 1'b1; row.c.pos_z = 32'sh80000000; row.c.dir_z = 32'h1;
    row.c.dir_y = 32'h7fffffff; dirs.push_back(row);
    foreach (dirs[i]) begin
      issue(dirs[i].c, dirs[i].chk, dirs[i].r);
    end
    drain();

    // directed extremes of the plane
    set_plane(16'h4000, 16'hc000, 16'hc000, 32'h80000000);
    c = '0; c.pos_x = 32'h80000000; c.pos_y = 32'h7fffffff; c.pos_z = 32'h7fffffff;
    issue(c, 1'b0, '0);
    c.mode = 1'b1; c.dir_x = 32'h7fffffff; c.dir_y = 32'h1; c.dir_z = 32'h80000000;
    issue(c, 1'b0, '0);
    drain();
    set_plane(16'h7fff, 16'h8000, 16'h0, 32'h7fffffff);
    c = '1; issue(c, 1'b0, '0);
    c.mode = 1'b0; issue(c, 1'b0, '0);
    drain();

    // random phases, new plane each phase
    for (ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 54;
        2: idle_pct = 22;
        default: idle_pct = 54;
      endcase
      if (ph == 0) set_plane(16'h0, 16'h0, 16'h4000, 32'h0);
      else if (ph == 11) set_plane(16'h4000, 16'h4000, 16'h4000, 32'h7fffffff);
      else set_plane(rand_normal(), rand_normal(), rand_normal(), rand_coord());
      for (int i = 0; i < N_RANDOM / 12; i++) begin
        c.mode = $urandom_range(3) != 0;
        c.pos_x = rand_coord(); c.pos_y = rand_coord(); c.pos_z = rand_coord();
        c.dir_x = rand_coord(); c.dir_y = rand_coord(); c.dir_z = rand_coord();
        if ($urandom_range(15) == 0) begin
          c.dir_x = 0; c.dir_y = 0; c.dir_z = 0;
        end
        issue(c, 1'b0, '0);
      end
      drain();
    end

    if (errors == 0 && pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// File: files.f
rtl/core/pdli_pkg.sv
rtl/core/pdli_div.sv
rtl/core/plane_distance_line_intersect.sv
tb/plane_distance_line_intersect_test.sv
